### design/dpc_pkg.sv
// Shared constants and types for the dark pixel centroid block.
`default_nettype none
package dpc_pkg;

  // Fixed port field widths
  localparam int VALUE_BITS      = 8;
  localparam int COORD_PORT_BITS = 12;
  localparam int COUNT_PORT_BITS = 13;
  localparam int THRESH_BITS     = 9;

  localparam logic [THRESH_BITS-1:0] THRESH_RESET = 9'd100;

  // Parameter defaults
  localparam int COORD_BITS_DEF        = 12;
  localparam int MAX_WINDOW_PIXELS_DEF = 4096;

  // Per-pixel command from the sequencer to the accumulator
  typedef struct packed {
    logic take;  // pixel transfer this cycle
    logic last;  // pixel closes the window
  } acc_cmd_t;

endpackage
`default_nettype wire

### design/dpc_accum.sv
// Window accumulator: coordinate sums, hit and pixel counts, window corners.
`default_nettype none
module dpc_accum #(
  parameter int COORD_BITS        = dpc_pkg::COORD_BITS_DEF,
  parameter int MAX_WINDOW_PIXELS = dpc_pkg::MAX_WINDOW_PIXELS_DEF,
  parameter int CNT_BITS          = $clog2(MAX_WINDOW_PIXELS + 1),
  parameter int SUM_BITS          = COORD_BITS + CNT_BITS
) (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  dpc_pkg::acc_cmd_t                   cmd_i,
  input  wire [dpc_pkg::VALUE_BITS-1:0]       value_i,
  input  wire [COORD_BITS-1:0]                col_i,
  input  wire [COORD_BITS-1:0]                row_i,
  input  wire [dpc_pkg::THRESH_BITS-1:0]      thresh_i,
  output logic [SUM_BITS-1:0]                 col_sum_o,
  output logic [SUM_BITS-1:0]                 row_sum_o,
  output logic [CNT_BITS-1:0]                 hit_count_o,
  output logic [COORD_BITS-1:0]               first_col_o,
  output logic [COORD_BITS-1:0]               first_row_o,
  output logic [COORD_BITS-1:0]               last_col_o,
  output logic [COORD_BITS-1:0]               last_row_o,
  output logic                                overflow_o
);

  logic                  in_window_q, in_window_d;
  logic                  ovf_q, ovf_d;
  logic [CNT_BITS-1:0]   pix_cnt_q, pix_cnt_d;
  logic [CNT_BITS-1:0]   hit_cnt_q, hit_cnt_d;
  logic [SUM_BITS-1:0]   col_sum_q, col_sum_d;
  logic [SUM_BITS-1:0]   row_sum_q, row_sum_d;
  logic [COORD_BITS-1:0] first_col_q, first_row_q;
  logic [COORD_BITS-1:0] last_col_q, last_row_q;

  logic                  win_start;
  logic                  full;
  logic                  hit;
  logic [CNT_BITS-1:0]   pix_base, hit_base;
  logic [SUM_BITS-1:0]   col_base, row_base;

  assign win_start = !in_window_q;
  assign hit       = dpc_pkg::THRESH_BITS'(value_i) < thresh_i;

  always_comb begin
    pix_base = win_start ? '0 : pix_cnt_q;
    hit_base = win_start ? '0 : hit_cnt_q;
    col_base = win_start ? '0 : col_sum_q;
    row_base = win_start ? '0 : row_sum_q;
    // pixels past the limit only raise the flag
    full     = (pix_base == CNT_BITS'(MAX_WINDOW_PIXELS));

    ovf_d       = (win_start ? 1'b0 : ovf_q) | full;
    pix_cnt_d   = pix_base;
    hit_cnt_d   = hit_base;
    col_sum_d   = col_base;
    row_sum_d   = row_base;
    if (!full) begin
      pix_cnt_d = pix_base + CNT_BITS'(1);
      if (hit) begin
        hit_cnt_d = hit_base + CNT_BITS'(1);
        col_sum_d = col_base + SUM_BITS'(col_i);
        row_sum_d = row_base + SUM_BITS'(row_i);
      end
    end
    in_window_d = !cmd_i.last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_window_q <= 1'b0;
      ovf_q       <= 1'b0;
      pix_cnt_q   <= '0;
      hit_cnt_q   <= '0;
      col_sum_q   <= '0;
      row_sum_q   <= '0;
      first_col_q <= '0;
      first_row_q <= '0;
    end else if (cmd_i.take) begin
      in_window_q <= in_window_d;
      ovf_q       <= ovf_d;
      pix_cnt_q   <= pix_cnt_d;
      hit_cnt_q   <= hit_cnt_d;
      col_sum_q   <= col_sum_d;
      row_sum_q   <= row_sum_d;
      if (win_start) begin
        first_col_q <= col_i;
        first_row_q <= row_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take && cmd_i.last) begin
      last_col_q <= col_i;
      last_row_q <= row_i;
    end
  end

  assign col_sum_o   = col_sum_q;
  assign row_sum_o   = row_sum_q;
  assign hit_count_o = hit_cnt_q;
  assign first_col_o = first_col_q;
  assign first_row_o = first_row_q;
  assign last_col_o  = last_col_q;
  assign last_row_o  = last_row_q;
  assign overflow_o  = ovf_q;

endmodule
`default_nettype wire

### design/dpc_divider.sv
// Shared restoring divider, one quotient bit per cycle.
`default_nettype none
module dpc_divider #(
  parameter int COORD_BITS = dpc_pkg::COORD_BITS_DEF,
  parameter int CNT_BITS   = $clog2(dpc_pkg::MAX_WINDOW_PIXELS_DEF + 1),
  parameter int SUM_BITS   = COORD_BITS + CNT_BITS
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   start_i,
  input  wire [SUM_BITS-1:0]    dividend_i,
  input  wire [CNT_BITS-1:0]    divisor_i,
  output logic                  done_o,
  output logic [COORD_BITS-1:0] quotient_o
);

  localparam int STEP_BITS = $clog2(SUM_BITS + 1);

  logic                 run_q;
  logic                 done_q;
  logic [STEP_BITS-1:0] step_q;
  logic [SUM_BITS-1:0]  quo_q;
  logic [CNT_BITS-1:0]  rem_q;
  logic [CNT_BITS-1:0]  dvs_q;

  logic [CNT_BITS:0]    trial;
  logic [CNT_BITS:0]    diff;
  logic                 fits;

  // remainder stays below the divisor, so one extra bit holds the shift
  assign trial = {rem_q, quo_q[SUM_BITS-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign fits  = trial >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q  <= 1'b1;
        step_q <= STEP_BITS'(SUM_BITS);
      end else if (run_q) begin
        step_q <= step_q - STEP_BITS'(1);
        if (step_q == STEP_BITS'(1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (run_q) begin
      quo_q <= {quo_q[SUM_BITS-2:0], fits};
      rem_q <= fits ? diff[CNT_BITS-1:0] : trial[CNT_BITS-1:0];
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q[COORD_BITS-1:0];

endmodule
`default_nettype wire

### design/dark_pixel_centroid.sv
// Top level: dark pixel centroid over one raster window.
//
//  channel   | handshake                    | payload
//  ----------+------------------------------+----------------------------------------
//  pixel in  | start, busy                  | pixel_value_i, pixel_col_i, pixel_row_i,
//            |                              | window_last_i
//  result    | result_strobe_o (one cycle)  | centre_col_o, centre_row_o, any_dark_o,
//            |                              | dark_count_o, window_overflow_o
//  config    | cfg_valid, cfg_ready         | cfg_data_i (dark threshold)
//
// A pixel without window_last leaves busy low; pixels may follow back to back.
// The last pixel of a window raises busy while the shared serial divider, which steps
// through all SUM_BITS dividend bits (SUM_BITS = COORD_BITS + clog2(MAX_WINDOW_PIXELS+1),
// 25 at defaults), forms the column and then the row centre; a window with no dark
// pixel skips the divider and reports the window centre.
// Reset clears the window state and loads a threshold of 100.
// The result strobe lasts one cycle; the receiver cannot stall it.
`default_nettype none
module dark_pixel_centroid #(
  parameter int COORD_BITS        = dpc_pkg::COORD_BITS_DEF,
  parameter int MAX_WINDOW_PIXELS = dpc_pkg::MAX_WINDOW_PIXELS_DEF
) (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  input  wire                                   start,
  output logic                                  busy,
  input  wire [dpc_pkg::VALUE_BITS-1:0]         pixel_value_i,
  input  wire [dpc_pkg::COORD_PORT_BITS-1:0]    pixel_col_i,
  input  wire [dpc_pkg::COORD_PORT_BITS-1:0]    pixel_row_i,
  input  wire                                   window_last_i,
  output logic                                  result_strobe_o,
  output logic [dpc_pkg::COORD_PORT_BITS-1:0]   centre_col_o,
  output logic [dpc_pkg::COORD_PORT_BITS-1:0]   centre_row_o,
  output logic                                  any_dark_o,
  output logic [dpc_pkg::COUNT_PORT_BITS-1:0]   dark_count_o,
  output logic                                  window_overflow_o,
  input  wire                                   cfg_valid,
  output logic                                  cfg_ready,
  input  wire [dpc_pkg::THRESH_BITS-1:0]        cfg_data_i
);

  localparam int CNT_BITS = $clog2(MAX_WINDOW_PIXELS + 1);
  localparam int SUM_BITS = COORD_BITS + CNT_BITS;
  localparam int CX = (COORD_BITS > dpc_pkg::COORD_PORT_BITS) ?
                      COORD_BITS : dpc_pkg::COORD_PORT_BITS;
  localparam int KX = (CNT_BITS > dpc_pkg::COUNT_PORT_BITS) ?
                      CNT_BITS : dpc_pkg::COUNT_PORT_BITS;

  localparam logic [1:0] S_IDLE    = 2'd0;
  localparam logic [1:0] S_LAUNCH  = 2'd1;
  localparam logic [1:0] S_DIV_COL = 2'd2;
  localparam logic [1:0] S_DIV_ROW = 2'd3;

  logic [1:0]                      state_q, state_d;
  logic [dpc_pkg::THRESH_BITS-1:0] thresh_q;
  logic                            strobe_q;
  logic [COORD_BITS-1:0]           col_quo_q;
  logic [COORD_BITS-1:0]           out_col_q, out_row_q, out_col_d, out_row_d;
  logic                            any_dark_q;
  logic [CNT_BITS-1:0]             count_q;
  logic                            ovf_q;
  logic                            load_out;

  logic                            accept;
  dpc_pkg::acc_cmd_t               acc_cmd;
  logic [CX-1:0]                   col_wide, row_wide;
  logic [COORD_BITS-1:0]           col_c, row_c;

  logic [SUM_BITS-1:0]             col_sum, row_sum;
  logic [CNT_BITS-1:0]             hit_count;
  logic [COORD_BITS-1:0]           first_col, first_row, last_col, last_row;
  logic                            overflow;
  logic [COORD_BITS-1:0]           size_col, size_row, mid_col, mid_row;

  logic                            div_start;
  logic [SUM_BITS-1:0]             div_dividend;
  logic                            div_done;
  logic [COORD_BITS-1:0]           div_quotient;

  logic [CX-1:0]                   out_col_wide, out_row_wide;
  logic [KX-1:0]                   count_wide;

  assign accept       = start && !busy;
  assign acc_cmd.take = accept;
  assign acc_cmd.last = window_last_i;

  assign col_wide = CX'(pixel_col_i);
  assign row_wide = CX'(pixel_row_i);
  assign col_c    = col_wide[COORD_BITS-1:0];
  assign row_c    = row_wide[COORD_BITS-1:0];

  dpc_accum #(
    .COORD_BITS        (COORD_BITS),
    .MAX_WINDOW_PIXELS (MAX_WINDOW_PIXELS),
    .CNT_BITS          (CNT_BITS),
    .SUM_BITS          (SUM_BITS)
  ) u_accum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (acc_cmd),
    .value_i     (pixel_value_i),
    .col_i       (col_c),
    .row_i       (row_c),
    .thresh_i    (thresh_q),
    .col_sum_o   (col_sum),
    .row_sum_o   (row_sum),
    .hit_count_o (hit_count),
    .first_col_o (first_col),
    .first_row_o (first_row),
    .last_col_o  (last_col),
    .last_row_o  (last_row),
    .overflow_o  (overflow)
  );

  dpc_divider #(
    .COORD_BITS (COORD_BITS),
    .CNT_BITS   (CNT_BITS),
    .SUM_BITS   (SUM_BITS)
  ) u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (hit_count),
    .done_o     (div_done),
    .quotient_o (div_quotient)
  );

  // window centre for the no-hit case, all modulo 2^COORD_BITS
  assign size_col = last_col - first_col + COORD_BITS'(1);
  assign size_row = last_row - first_row + COORD_BITS'(1);
  assign mid_col  = first_col + (size_col >> 1);
  assign mid_row  = first_row + (size_row >> 1);

  always_comb begin
    state_d      = state_q;
    div_start    = 1'b0;
    div_dividend = col_sum;
    load_out     = 1'b0;
    out_col_d    = mid_col;
    out_row_d    = mid_row;
    case (state_q)
      S_IDLE: begin
        if (accept && window_last_i) state_d = S_LAUNCH;
      end
      S_LAUNCH: begin
        if (hit_count == '0) begin
          load_out = 1'b1;
          state_d  = S_IDLE;
        end else begin
          div_start = 1'b1;
          state_d   = S_DIV_COL;
        end
      end
      S_DIV_COL: begin
        if (div_done) begin
          div_start    = 1'b1;
          div_dividend = row_sum;
          state_d      = S_DIV_ROW;
        end
      end
      S_DIV_ROW: begin
        if (div_done) begin
          load_out  = 1'b1;
          out_col_d = col_quo_q;
          out_row_d = div_quotient;
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      thresh_q <= dpc_pkg::THRESH_RESET;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      strobe_q <= load_out;
      if (cfg_valid && cfg_ready) thresh_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_DIV_COL && div_done) col_quo_q <= div_quotient;
    if (load_out) begin
      out_col_q  <= out_col_d;
      out_row_q  <= out_row_d;
      any_dark_q <= hit_count != '0;
      count_q    <= hit_count;
      ovf_q      <= overflow;
    end
  end

  assign out_col_wide = CX'(out_col_q);
  assign out_row_wide = CX'(out_row_q);
  assign count_wide   = KX'(count_q);

  assign busy              = state_q != S_IDLE;
  assign cfg_ready         = 1'b1;
  assign result_strobe_o   = strobe_q;
  assign centre_col_o      = out_col_wide[dpc_pkg::COORD_PORT_BITS-1:0];
  assign centre_row_o      = out_row_wide[dpc_pkg::COORD_PORT_BITS-1:0];
  assign any_dark_o        = any_dark_q;
  assign dark_count_o      = count_wide[dpc_pkg::COUNT_PORT_BITS-1:0];
  assign window_overflow_o = ovf_q;

`ifndef SYNTHESIS
  a_strobe_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o |-> ($past(state_q) == S_LAUNCH || $past(state_q) == S_DIV_ROW))
    else $error("result strobe without a finishing sequencer step");

  a_last_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && window_last_i) |=> busy)
    else $error("block not busy after last pixel transfer");

  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_DIV_COL || state_q == S_DIV_ROW))
    else $error("divider finished outside a divide step");

  a_no_hit_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_strobe_o && !any_dark_q) |-> (count_q == '0))
    else $error("nonzero count reported with no dark pixels");
`endif

endmodule
`default_nettype wire
